[rtl/core/scb_pkg.sv]
// ----------------------------------------------------------------------------
// Segment clip package
// Shared constants and types for the segment clip to box block.
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam int MaxDims = 16;
  localparam int DimW    = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int CntW    = $clog2(MaxDims + 1);
  localparam int CoordW  = 32;
  localparam int TolW    = 16;
  localparam logic [TolW-1:0] TolReset = TolW'(66);

  typedef struct packed {
    logic signed [CoordW-1:0] start_coord;
    logic signed [CoordW-1:0] end_coord;
    logic signed [CoordW-1:0] lower_limit;
    logic signed [CoordW-1:0] upper_limit;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic                     start;
    logic signed [CoordW:0]   num;
    logic signed [CoordW:0]   den;
  } div_req_t;

endpackage

[rtl/core/scb_if.sv]
// ----------------------------------------------------------------------------
// Segment clip channels
// Input, output and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface scb_in_if import scb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] start_coord;
  logic signed [CoordW-1:0] end_coord;
  logic signed [CoordW-1:0] lower_limit;
  logic signed [CoordW-1:0] upper_limit;
  logic                     last_dim;

  modport source (output valid, start_coord, end_coord, lower_limit, upper_limit,
                  last_dim, input ready);
  modport sink (input valid, start_coord, end_coord, lower_limit, upper_limit,
                last_dim, output ready);
endinterface

interface scb_out_if import scb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] result_coord;
  logic                     clipped;
  logic                     dims_dropped;
  logic                     last_coord;

  modport source (output valid, result_coord, clipped, dims_dropped, last_coord,
                  input ready);
  modport sink (input valid, result_coord, clipped, dims_dropped, last_coord,
                output ready);
endinterface

interface scb_cfg_if import scb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TolW-1:0] tolerance;

  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface

[rtl/core/scb_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module scb_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/scb_div.sv]
// ----------------------------------------------------------------------------
// Segment clip divider
// Radix-2 restoring divider for t = num * 2^30 / den, truncated, saturated.
// ----------------------------------------------------------------------------
module scb_div import scb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  div_req_t                 req_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] t_o
);

  localparam int QW = CoordW + 31;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [CoordW:0] rem_q, rem_d;
  logic [CoordW:0] den_q, den_d;
  logic [QW-1:0]   dq_q, dq_d;
  logic            neg_q, neg_d;
  logic [CoordW+1:0] trial;
  logic [CoordW:0] num_mag, den_mag;
  logic            big_pos, big_neg;

  always_comb begin
    num_mag = req_i.num[CoordW] ? (CoordW+1)'(-req_i.num) : req_i.num;
    den_mag = req_i.den[CoordW] ? (CoordW+1)'(-req_i.den) : req_i.den;
    trial   = {rem_q, dq_q[QW-1]};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    dq_d    = dq_q;
    neg_d   = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'(QW);
      rem_d  = '0;
      den_d  = den_mag;
      dq_d   = {num_mag, 30'b0};
      neg_d  = req_i.num[CoordW] ^ req_i.den[CoordW];
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = (CoordW+1)'(trial - {1'b0, den_q});
        dq_d  = {dq_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial[CoordW:0];
        dq_d  = {dq_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dq_q  <= dq_d;
    neg_q <= neg_d;
  end

  always_comb begin
    big_pos = dq_q[QW-1:CoordW-1] != '0;
    big_neg = (dq_q[QW-1:CoordW] != '0) || (dq_q[CoordW-1] && dq_q[CoordW-2:0] != '0);
    if (!neg_q) begin
      t_o = big_pos ? {1'b0, {(CoordW-1){1'b1}}} : dq_q[CoordW-1:0];
    end else begin
      t_o = big_neg ? {1'b1, {(CoordW-1){1'b0}}} : CoordW'(-dq_q[CoordW-1:0]);
    end
  end

  assign done_o = done_q;

endmodule

[rtl/core/segment_clip_to_box.sv]
// ----------------------------------------------------------------------------
// Segment clip to box
// Stores a segment and box one dimension per transaction, then clips the
// segment end to the box and returns one coordinate per stored dimension.
// ----------------------------------------------------------------------------
// Loading accepts one dimension per cycle while idle. After the final
// dimension the block scans the n stored dimensions: each candidate is
// fetched and evaluated, divided in the serial divider, then checked
// against every dimension in read, multiply and compare states, and each
// output coordinate passes read, multiply and compare states on the single
// read port of the store. Input is held off for the whole pass.
module segment_clip_to_box import scb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  scb_in_if.sink    in_i,
  scb_cfg_if.sink   cfg_i,
  scb_out_if.source out_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN_EV = 4'd2;
  localparam logic [3:0] S_DIV     = 4'd3;
  localparam logic [3:0] S_CHK_RD  = 4'd4;
  localparam logic [3:0] S_CHK_MUL = 4'd5;
  localparam logic [3:0] S_CHK_CMP = 4'd6;
  localparam logic [3:0] S_OUT_RD  = 4'd7;
  localparam logic [3:0] S_OUT_MUL = 4'd8;
  localparam logic [3:0] S_OUT_CMP = 4'd9;

  localparam int WideW = CoordW + 5;

  logic [3:0]            state_q, state_d;
  logic [CntW-1:0]       dims_q, dims_d, n_q, n_d, c_q, c_d, k_q, k_d;
  logic                  ovf_q, ovf_d, ok_q, ok_d, found_q, found_d;
  logic [TolW-1:0]       tol_q;
  logic signed [CoordW-1:0] t_q, t_d;
  logic signed [2*CoordW:0] prod_q, prod_d;
  logic                  ov_valid_q, ov_valid_d;
  logic signed [CoordW-1:0] ov_coord_q, ov_coord_d;
  logic                  ov_clip_q, ov_clip_d, ov_drop_q, ov_drop_d, ov_last_q, ov_last_d;

  logic                  we, re, in_acc, room;
  logic [DimW-1:0]       raddr;
  entry_t                wentry, rd;
  div_req_t              div_req;
  logic                  div_done;
  logic signed [CoordW-1:0] div_t;
  logic signed [CoordW:0]   den, num, bound;
  logic                  is_cand;
  logic signed [WideW-1:0]  cand, lo_w, hi_w;
  logic signed [CoordW-1:0] cand_sat;

  assign room   = dims_q < CntW'(MaxDims);
  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;

  assign wentry = '{start_coord: in_i.start_coord, end_coord: in_i.end_coord,
                    lower_limit: in_i.lower_limit, upper_limit: in_i.upper_limit};
  assign we = in_acc && room;

  scb_ram #(.Width(EntryW), .Depth(1 << DimW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (dims_q[DimW-1:0]),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  scb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .t_o    (div_t)
  );

  always_comb begin
    den = (CoordW+1)'(rd.end_coord) - (CoordW+1)'(rd.start_coord);
    if (rd.end_coord > rd.upper_limit) begin
      bound   = (CoordW+1)'(rd.upper_limit);
      is_cand = 1'b1;
    end else if (rd.end_coord < rd.lower_limit) begin
      bound   = (CoordW+1)'(rd.lower_limit);
      is_cand = 1'b1;
    end else begin
      bound   = '0;
      is_cand = 1'b0;
    end
    num  = bound - (CoordW+1)'(rd.start_coord);
    cand = WideW'(rd.start_coord) + WideW'(prod_q >>> 30);
    lo_w = WideW'(rd.lower_limit) - WideW'($signed({1'b0, tol_q}));
    hi_w = WideW'(rd.upper_limit) + WideW'($signed({1'b0, tol_q}));
    if (cand > WideW'(32'sh7FFF_FFFF)) begin
      cand_sat = 32'sh7FFF_FFFF;
    end else if (cand < -WideW'(33'sh0_8000_0000)) begin
      cand_sat = 32'sh8000_0000;
    end else begin
      cand_sat = cand[CoordW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    dims_d     = dims_q;
    n_d        = n_q;
    c_d        = c_q;
    k_d        = k_q;
    ovf_d      = ovf_q;
    ok_d       = ok_q;
    found_d    = found_q;
    t_d        = t_q;
    prod_d     = prod_q;
    re         = 1'b0;
    raddr      = c_q[DimW-1:0];
    div_req    = '{start: 1'b0, num: num, den: den};
    ov_valid_d = ov_valid_q && !out_o.ready;
    ov_coord_d = ov_coord_q;
    ov_clip_d  = ov_clip_q;
    ov_drop_d  = ov_drop_q;
    ov_last_d  = ov_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          dims_d = room ? dims_q + CntW'(1) : dims_q;
          ovf_d  = ovf_q || !room;
          if (in_i.last_dim) begin
            n_d     = room ? dims_q + CntW'(1) : dims_q;
            c_d     = '0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        re      = 1'b1;
        state_d = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (is_cand && den != '0) begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end else begin
          c_d = c_q + CntW'(1);
          if (c_q + CntW'(1) == n_q) begin
            found_d = 1'b0;
            k_d     = '0;
            state_d = S_OUT_RD;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          t_d     = div_t;
          k_d     = '0;
          ok_d    = 1'b1;
          state_d = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        re      = 1'b1;
        raddr   = k_q[DimW-1:0];
        state_d = S_CHK_MUL;
      end
      S_CHK_MUL: begin
        prod_d  = t_q * den;
        state_d = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (cand < lo_w || cand > hi_w) begin
          ok_d = 1'b0;
        end
        k_d = k_q + CntW'(1);
        if (k_q + CntW'(1) == n_q) begin
          if (ok_q && !(cand < lo_w || cand > hi_w)) begin
            found_d = 1'b1;
            k_d     = '0;
            state_d = S_OUT_RD;
          end else begin
            c_d = c_q + CntW'(1);
            if (c_q + CntW'(1) == n_q) begin
              found_d = 1'b0;
              k_d     = '0;
              state_d = S_OUT_RD;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end else begin
          state_d = S_CHK_RD;
        end
      end
      S_OUT_RD: begin
        re      = 1'b1;
        raddr   = k_q[DimW-1:0];
        state_d = S_OUT_MUL;
      end
      S_OUT_MUL: begin
        prod_d  = t_q * den;
        state_d = S_OUT_CMP;
      end
      S_OUT_CMP: begin
        if (!ov_valid_q || out_o.ready) begin
          ov_valid_d = 1'b1;
          ov_coord_d = found_q ? cand_sat : rd.end_coord;
          ov_clip_d  = found_q;
          ov_drop_d  = ovf_q;
          ov_last_d  = k_q + CntW'(1) == n_q;
          k_d        = k_q + CntW'(1);
          if (k_q + CntW'(1) == n_q) begin
            dims_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      dims_q     <= '0;
      n_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      ovf_q      <= 1'b0;
      ok_q       <= 1'b0;
      found_q    <= 1'b0;
      tol_q      <= TolReset;
      ov_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      dims_q     <= dims_d;
      n_q        <= n_d;
      c_q        <= c_d;
      k_q        <= k_d;
      ovf_q      <= ovf_d;
      ok_q       <= ok_d;
      found_q    <= found_d;
      ov_valid_q <= ov_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        tol_q <= cfg_i.tolerance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    prod_q     <= prod_d;
    ov_coord_q <= ov_coord_d;
    ov_clip_q  <= ov_clip_d;
    ov_drop_q  <= ov_drop_d;
    ov_last_q  <= ov_last_d;
  end

  assign out_o.valid        = ov_valid_q;
  assign out_o.result_coord = ov_coord_q;
  assign out_o.clipped      = ov_clip_q;
  assign out_o.dims_dropped = ov_drop_q;
  assign out_o.last_coord   = ov_last_q;

`ifndef SYNTHESIS
  a_dims_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dims_q <= CntW'(MaxDims)) else $error("Stored dimension count exceeds the store.");
  a_pass_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (n_q != '0 && n_q <= CntW'(MaxDims)))
    else $error("Pass count out of range.");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("Divider finished outside a division.");
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_CMP && state_d == S_IDLE) |=> (dims_q == '0 && !ovf_q))
    else $error("Point state not cleared after the pass.");
`endif

endmodule
